### design/sialu_pkg.sv
package sialu_pkg;

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_REM = 3'd4
  } func_e;

  // Control that travels down the pipeline next to each beat.
  typedef struct packed {
    logic valid;
    logic sel_res;   // add, subtract or multiply: the result is carried as is
    logic sel_quo;   // divide
    logic sel_rem;   // remainder
    logic neg_quo;   // operand signs differ
    logic neg_rem;   // dividend is negative
    logic zero_div;  // divide or remainder with a zero divisor
  } ctl_t;

endpackage

### design/sialu_prep.sv
module sialu_prep
  import sialu_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [2:0]          func_i,
  input  logic signed [W-1:0] operand_a_i,
  input  logic signed [W-1:0] operand_b_i,
  output ctl_t                ctl_o,
  output logic [W-1:0]        res_o,
  output logic [W-1:0]        mag_a_o,
  output logic [W-1:0]        mag_b_o
);

  localparam int unsigned LO  = W / 2;
  localparam int unsigned HI  = W - LO;
  localparam int unsigned LO2 = 2 * LO;

  // First stage: decode, add or subtract, magnitudes and partial products.
  ctl_t          ctl_a_d, ctl_a_q;
  logic          mul_a_d, mul_a_q;
  logic [W-1:0]  res_a_d, res_a_q;
  logic [W-1:0]  mag_a_d, mag_a_q;
  logic [W-1:0]  mag_b_d, mag_b_q;
  logic [LO2-1:0] pp_ll_d, pp_ll_q;
  logic [HI-1:0] pp_hl_d, pp_hl_q;
  logic [HI-1:0] pp_lh_d, pp_lh_q;

  logic [LO-1:0] a_lo, b_lo;
  logic [HI-1:0] a_hi, b_hi;
  logic          a_neg, b_neg, b_zero;

  assign a_lo   = operand_a_i[LO-1:0];
  assign b_lo   = operand_b_i[LO-1:0];
  assign a_hi   = operand_a_i[W-1:LO];
  assign b_hi   = operand_b_i[W-1:LO];
  assign a_neg  = operand_a_i[W-1];
  assign b_neg  = operand_b_i[W-1];
  assign b_zero = (operand_b_i == '0);

  always_comb begin
    ctl_a_d         = '0;
    ctl_a_d.valid   = valid_i;
    ctl_a_d.neg_quo = a_neg ^ b_neg;
    ctl_a_d.neg_rem = a_neg;
    mul_a_d         = 1'b0;
    res_a_d         = operand_a_i + operand_b_i;
    case (func_e'(func_i))
      FUNC_ADD: begin
        ctl_a_d.sel_res = 1'b1;
      end
      FUNC_SUB: begin
        ctl_a_d.sel_res = 1'b1;
        res_a_d         = operand_a_i - operand_b_i;
      end
      FUNC_MUL: begin
        ctl_a_d.sel_res = 1'b1;
        mul_a_d         = 1'b1;
      end
      FUNC_DIV: begin
        ctl_a_d.sel_quo  = 1'b1;
        ctl_a_d.zero_div = b_zero;
      end
      FUNC_REM: begin
        ctl_a_d.sel_rem  = 1'b1;
        ctl_a_d.zero_div = b_zero;
      end
      default: begin
        ctl_a_d.sel_res = 1'b0;
      end
    endcase
  end

  assign mag_a_d = a_neg ? (W'(0) - operand_a_i) : operand_a_i;
  assign mag_b_d = b_neg ? (W'(0) - operand_b_i) : operand_b_i;

  // The low word of the product needs only the low-by-low product and the
  // low bits of the two cross products.
  assign pp_ll_d = LO2'(a_lo) * LO2'(b_lo);
  assign pp_hl_d = a_hi * HI'(b_lo);
  assign pp_lh_d = HI'(a_lo) * b_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
    end else begin
      ctl_a_q <= ctl_a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_a_q <= mul_a_d;
    res_a_q <= res_a_d;
    mag_a_q <= mag_a_d;
    mag_b_q <= mag_b_d;
    pp_ll_q <= pp_ll_d;
    pp_hl_q <= pp_hl_d;
    pp_lh_q <= pp_lh_d;
  end

  // Second stage: assemble the product.
  logic [HI-1:0] cross_sum;
  logic [W-1:0]  prod;
  logic [W-1:0]  res_b_d, res_b_q;

  assign cross_sum = pp_hl_q + pp_lh_q;
  assign prod      = W'(pp_ll_q) + {cross_sum, {LO{1'b0}}};
  assign res_b_d   = mul_a_q ? prod : res_a_q;

  ctl_t ctl_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
    end else begin
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_b_q <= res_b_d;
    mag_a_o <= mag_a_q;
    mag_b_o <= mag_b_q;
  end

  assign ctl_o = ctl_b_q;
  assign res_o = res_b_q;

endmodule

### design/sialu_div_stage.sv
module sialu_div_stage
  import sialu_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ctl_t         ctl_i,
  input  logic [W-1:0] res_i,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] dq_i,
  input  logic [W-1:0] div_i,
  output ctl_t         ctl_o,
  output logic [W-1:0] res_o,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] dq_o,
  output logic [W-1:0] div_o
);

  // One restoring step: dividend bits shift out of the top of dq while
  // quotient bits shift in at the bottom.
  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         fits;
  logic [W-1:0] rem_d, dq_d;

  assign trial = {rem_i, dq_i[W-1]};
  assign diff  = trial - {1'b0, div_i};
  assign fits  = ~diff[W];
  assign rem_d = fits ? diff[W-1:0] : trial[W-1:0];
  assign dq_d  = {dq_i[W-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_i;
    rem_o <= rem_d;
    dq_o  <= dq_d;
    div_o <= div_i;
  end

endmodule

### design/sialu_finish.sv
module sialu_finish
  import sialu_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_t                ctl_i,
  input  logic [W-1:0]        res_i,
  input  logic [W-1:0]        rem_i,
  input  logic [W-1:0]        quo_i,
  output logic                done_o,
  output logic signed [W-1:0] result_value_o,
  output logic                zero_divisor_o
);

  logic [W-1:0] value_d;
  logic         done_d;

  assign done_d = ctl_i.valid;

  always_comb begin
    value_d = '0;
    if (ctl_i.sel_res) begin
      value_d = res_i;
    end else if (ctl_i.zero_div) begin
      value_d = '0;
    end else if (ctl_i.sel_quo) begin
      value_d = ctl_i.neg_quo ? (W'(0) - quo_i) : quo_i;
    end else if (ctl_i.sel_rem) begin
      value_d = ctl_i.neg_rem ? (W'(0) - rem_i) : rem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_value_o <= value_d;
    zero_divisor_o <= ctl_i.zero_div;
  end

endmodule

### design/signed_integer_alu_with_divide_top.sv
// Signed integer ALU: add, subtract, low product, quotient and remainder.
//
// Input: drive func_i, operand_a_i and operand_b_i with start high; the beat
// is taken at any edge where busy is low. busy stays low, so a new operation
// may be issued every cycle.
// Output: done_o is high for exactly one cycle with result_value_o and
// zero_divisor_o; the receiver must take the beat in that cycle, since it
// cannot hold results off.
// Structure: two input stages form magnitudes and the product, then the
// divider is one stage per quotient bit, then a stage fixes signs and picks
// the result; every operation passes through all of these stages.
// Throughput: one operation per cycle.
// Quotients truncate toward zero, remainders take the dividend's sign, and a
// zero divisor gives 0 with zero_divisor_o set. Codes 5 to 7 give 0.
// Reset clears the valid bits of all stages; beats in flight are dropped and
// done_o is low until the first new result comes out.
module signed_integer_alu_with_divide_top
  import sialu_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   func_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] result_value_o,
  output logic                         zero_divisor_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned LAT = W + 3;

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ctl_t         ctl_s [W+1];
  logic [W-1:0] res_s [W+1];
  logic [W-1:0] rem_s [W+1];
  logic [W-1:0] dq_s  [W+1];
  logic [W-1:0] div_s [W+1];

  sialu_prep #(.W(W)) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .func_i      (func_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .ctl_o       (ctl_s[0]),
    .res_o       (res_s[0]),
    .mag_a_o     (dq_s[0]),
    .mag_b_o     (div_s[0])
  );

  assign rem_s[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_div
    sialu_div_stage #(.W(W)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_s[i]),
      .res_i  (res_s[i]),
      .rem_i  (rem_s[i]),
      .dq_i   (dq_s[i]),
      .div_i  (div_s[i]),
      .ctl_o  (ctl_s[i+1]),
      .res_o  (res_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .dq_o   (dq_s[i+1]),
      .div_o  (div_s[i+1])
    );
  end

  sialu_finish #(.W(W)) u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl_s[W]),
    .res_i          (res_s[W]),
    .rem_i          (rem_s[W]),
    .quo_i          (dq_s[W]),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .zero_divisor_o (zero_divisor_o)
  );

  // Every accepted operation comes out as a done_o result.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("accepted operation produced no result");

  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result without a matching accepted operation");

  a_zero_div_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_divisor_o) |-> (result_value_o == '0)
                                   && ($past(operand_b_i, LAT) == '0))
    else $error("zero divisor flag inconsistent with result or divisor");

endmodule
